FILE: rtl/core/atlas_shelf_allocator_assert.svh
// Assertion macros for the atlas shelf allocator.
// Used by the checker; expects clock and reset in the enclosing scope.
`ifndef ATLAS_SHELF_ALLOCATOR_ASSERT_SVH
`define ATLAS_SHELF_ALLOCATOR_ASSERT_SVH

// Check a property on an explicit clock and reset.
`define ASA_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("atlas shelf allocator assertion failed");

// Check a property on the local clock and reset.
`define ASA_ASSERT(label, prop) \
   `ASA_ASSERT_CLK(label, clock, reset, prop)

`endif

FILE: rtl/core/asa_pkg.sv
// Shared types and constants of the atlas shelf allocator.
// No dependencies; imported by every module of the block.
package asa_pkg;

   localparam int DIM_W  = 12;
   localparam int SIZE_W = 13;
   localparam int NEED_W = 14;

   localparam int DEF_START_WIDTH    = 512;
   localparam int DEF_START_HEIGHT   = 256;
   localparam int DEF_MAX_SIZE       = 4096;
   localparam int DEF_DOUBLING_LIMIT = 2048;
   localparam int DEF_HEIGHT_STEP    = 1024;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_SPACE = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [DIM_W-1:0]  cell_width;
      logic [DIM_W-1:0]  cell_height;
   } asa_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DIM_W-1:0]  origin_x;
      logic [DIM_W-1:0]  origin_y;
      logic [SIZE_W-1:0] atlas_width;
      logic [SIZE_W-1:0] atlas_height;
   } asa_rsp_type;

   typedef struct packed {
      logic       load;
      logic       restart;
      logic       widen_step;
      logic       width_commit;
      logic       wrap;
      logic       grow_step;
      logic       place;
      logic       set_status;
      logic [1:0] status_code;
   } asa_cmd_type;

   typedef struct packed {
      logic is_restart;
      logic is_zero;
      logic widen_exit;
      logic widen_fit;
      logic grow_exit;
      logic grow_fit;
   } asa_sts_type;

endpackage

FILE: rtl/core/asa_dp.sv
// Datapath of the atlas shelf allocator: atlas state, growth units, result.
// Depends on asa_pkg; driven by asa_ctrl through asa_cmd_type.
module asa_dp import asa_pkg::*; #(
   parameter int START_WIDTH    = DEF_START_WIDTH,
   parameter int START_HEIGHT   = DEF_START_HEIGHT,
   parameter int MAX_SIZE       = DEF_MAX_SIZE,
   parameter int DOUBLING_LIMIT = DEF_DOUBLING_LIMIT,
   parameter int HEIGHT_STEP    = DEF_HEIGHT_STEP
) (
   input  logic        clock,
   input  logic        reset,
   input  asa_req_type req_payload,
   input  asa_cmd_type cmd,
   output asa_sts_type sts,
   output asa_rsp_type rsp_payload
);

   localparam logic [SIZE_W-1:0] START_W_C = SIZE_W'(START_WIDTH);
   localparam logic [SIZE_W-1:0] START_H_C = SIZE_W'(START_HEIGHT);
   localparam logic [SIZE_W-1:0] MAX_C     = SIZE_W'(MAX_SIZE);
   localparam logic [SIZE_W-1:0] DLIM_C    = SIZE_W'(DOUBLING_LIMIT);
   localparam logic [SIZE_W-1:0] STEP_C    = SIZE_W'(HEIGHT_STEP);

   asa_req_type       req_ff, req_in;
   logic [SIZE_W-1:0] nw_ff, nw_in;
   logic [SIZE_W-1:0] nh_ff, nh_in;
   logic [SIZE_W-1:0] pen_ff, pen_in;
   logic [SIZE_W-1:0] top_ff, top_in;
   logic [SIZE_W-1:0] shelf_ff, shelf_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [1:0]        status_ff, status_in;
   logic [DIM_W-1:0]  ox_ff, ox_in;
   logic [DIM_W-1:0]  oy_ff, oy_in;

   logic [SIZE_W-1:0] cw_ext, ch_ext;
   logic [NEED_W-1:0] pen_end;
   logic [NEED_W-1:0] grow_need;
   logic [NEED_W-1:0] nh_ext;
   logic [SIZE_W-1:0] nh_next;

   assign cw_ext    = SIZE_W'(req_ff.cell_width);
   assign ch_ext    = SIZE_W'(req_ff.cell_height);
   assign pen_end   = NEED_W'(pen_ff) + NEED_W'(req_ff.cell_width);
   assign grow_need = NEED_W'(top_ff) + NEED_W'(req_ff.cell_height);
   assign nh_ext    = NEED_W'(nh_ff);

   always_comb begin
      if (nh_ff < DLIM_C) begin
         nh_next = (nh_ff == '0) ? SIZE_W'(1) : {nh_ff[SIZE_W-2:0], 1'b0};
      end else begin
         nh_next = nh_ff + STEP_C;
      end
   end

   always_comb begin
      sts.is_restart = (req_ff.cmd == CMD_RESTART);
      sts.is_zero    = (req_ff.cell_width == '0) || (req_ff.cell_height == '0);
      sts.widen_exit = (nw_ff >= cw_ext) || (nw_ff >= MAX_C) || (nw_ff == '0);
      sts.widen_fit  = (nw_ff <= MAX_C) && (nw_ff >= cw_ext);
      sts.grow_exit  = (nh_ext >= grow_need) || (nh_ff >= MAX_C);
      sts.grow_fit   = (nh_ff <= MAX_C) && (nh_ext >= grow_need);
   end

   always_comb begin
      req_in    = req_ff;
      nw_in     = nw_ff;
      nh_in     = nh_ff;
      pen_in    = pen_ff;
      top_in    = top_ff;
      shelf_in  = shelf_ff;
      width_in  = width_ff;
      height_in = height_ff;
      status_in = status_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      if (cmd.load) begin
         req_in    = req_payload;
         nw_in     = width_ff;
         status_in = STATUS_OK;
         ox_in     = '0;
         oy_in     = '0;
      end
      if (cmd.restart) begin
         pen_in    = '0;
         top_in    = '0;
         shelf_in  = '0;
         width_in  = START_W_C;
         height_in = START_H_C;
      end
      if (cmd.widen_step) begin
         nw_in = {nw_ff[SIZE_W-2:0], 1'b0};
      end
      if (cmd.width_commit) begin
         width_in = nw_ff;
      end
      if (cmd.wrap) begin
         nh_in = height_ff;
         if (pen_end > NEED_W'(width_ff)) begin
            pen_in   = '0;
            top_in   = top_ff + shelf_ff;
            shelf_in = '0;
         end
      end
      if (cmd.grow_step) begin
         nh_in = nh_next;
      end
      if (cmd.place) begin
         height_in = nh_ff;
         if (ch_ext > shelf_ff) begin
            shelf_in = ch_ext;
         end
         ox_in  = pen_ff[DIM_W-1:0];
         oy_in  = top_ff[DIM_W-1:0];
         pen_in = pen_end[SIZE_W-1:0];
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      nw_ff     <= nw_in;
      nh_ff     <= nh_in;
      status_ff <= status_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff    <= '0;
         top_ff    <= '0;
         shelf_ff  <= '0;
         width_ff  <= START_W_C;
         height_ff <= START_H_C;
      end else begin
         pen_ff    <= pen_in;
         top_ff    <= top_in;
         shelf_ff  <= shelf_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      rsp_payload.status       = status_ff;
      rsp_payload.origin_x     = ox_ff;
      rsp_payload.origin_y     = oy_ff;
      rsp_payload.atlas_width  = width_ff;
      rsp_payload.atlas_height = height_ff;
   end

endmodule

FILE: rtl/core/asa_ctrl.sv
// Controller of the atlas shelf allocator: sequences check, widen, wrap, grow.
// Depends on asa_pkg; commands asa_dp and reads its status.
module asa_ctrl import asa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  asa_sts_type sts,
   output asa_cmd_type cmd,
   output logic        busy,
   output logic        rsp_valid
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_WIDEN = 6'b000100,
      ST_WRAP  = 6'b001000,
      ST_GROW  = 6'b010000,
      ST_RESP  = 6'b100000
   } asa_state_type;

   asa_state_type state_ff, state_in;
   logic          accept;

   assign busy      = (state_ff != ST_IDLE) && (state_ff != ST_RESP);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_restart) begin
               cmd.restart = 1'b1;
               state_in    = ST_RESP;
            end else if (sts.is_zero) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_ZERO;
               state_in        = ST_RESP;
            end else begin
               state_in = ST_WIDEN;
            end
         end
         ST_WIDEN: begin
            if (!sts.widen_exit) begin
               cmd.widen_step = 1'b1;
            end else if (sts.widen_fit) begin
               cmd.width_commit = 1'b1;
               state_in         = ST_WRAP;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_SPACE;
               state_in        = ST_RESP;
            end
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = ST_GROW;
         end
         ST_GROW: begin
            if (!sts.grow_exit) begin
               cmd.grow_step = 1'b1;
            end else if (sts.grow_fit) begin
               cmd.place = 1'b1;
               state_in  = ST_RESP;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_SPACE;
               state_in        = ST_RESP;
            end
         end
         ST_RESP: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/atlas_shelf_allocator.sv
// Restart and zero-size beats pass through the check state to the result state;
// allocations go through check, W width doublings, wrap and H height growth steps
// unless space runs out, one step a cycle in the separate widen and grow registers.
// A new beat is taken in the cycle its predecessor's result is shown.
// Synchronous reset empties the atlas at its start size; results cannot stall.
module atlas_shelf_allocator import asa_pkg::*; #(
   parameter int START_WIDTH    = DEF_START_WIDTH,
   parameter int START_HEIGHT   = DEF_START_HEIGHT,
   parameter int MAX_SIZE       = DEF_MAX_SIZE,
   parameter int DOUBLING_LIMIT = DEF_DOUBLING_LIMIT,
   parameter int HEIGHT_STEP    = DEF_HEIGHT_STEP
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  asa_req_type req_payload,
   output logic        rsp_valid,
   output asa_rsp_type rsp_payload
);

   asa_cmd_type dp_cmd;
   asa_sts_type dp_sts;

   asa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (dp_sts),
      .cmd       (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   asa_dp #(
      .START_WIDTH    (START_WIDTH),
      .START_HEIGHT   (START_HEIGHT),
      .MAX_SIZE       (MAX_SIZE),
      .DOUBLING_LIMIT (DOUBLING_LIMIT),
      .HEIGHT_STEP    (HEIGHT_STEP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (dp_cmd),
      .sts         (dp_sts),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/asa_checker.sv
// Port-level checks of the atlas shelf allocator, bound to the top level.
// Depends on asa_pkg and atlas_shelf_allocator_assert.svh.
`include "atlas_shelf_allocator_assert.svh"

module asa_checker import asa_pkg::*; #(
   parameter int START_WIDTH  = DEF_START_WIDTH,
   parameter int START_HEIGHT = DEF_START_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input asa_req_type req_payload,
   input logic        rsp_valid,
   input asa_rsp_type rsp_payload
);

   localparam logic [SIZE_W-1:0] START_W_C = SIZE_W'(START_WIDTH);
   localparam logic [SIZE_W-1:0] START_H_C = SIZE_W'(START_HEIGHT);

   logic restart_beat;
   logic start_size;
   logic error_beat;
   logic origin_zero;

   assign restart_beat = start && !busy && (req_payload.cmd == CMD_RESTART);
   assign start_size   = rsp_valid && (rsp_payload.status == STATUS_OK) &&
                         (rsp_payload.atlas_width == START_W_C) &&
                         (rsp_payload.atlas_height == START_H_C);
   assign error_beat   = rsp_valid && (rsp_payload.status != STATUS_OK);
   assign origin_zero  = (rsp_payload.origin_x == '0) && (rsp_payload.origin_y == '0);

   `ASA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid)
   `ASA_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !rsp_valid))
   `ASA_ASSERT(a_restart_rsp, restart_beat |=> ##1 start_size)
   `ASA_ASSERT(a_error_origin, error_beat |-> origin_zero)

endmodule

bind atlas_shelf_allocator asa_checker #(
   .START_WIDTH  (START_WIDTH),
   .START_HEIGHT (START_HEIGHT)
) u_asa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: verif/atlas_placement_checker.sv
// Placement checker for the atlas shelf allocator: predicts each result beat
// from the accepted request beats and compares it field by field.
// Depends on asa_pkg for the request and result payload types.
module atlas_placement_checker import asa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  asa_req_type req_payload,
   input  logic        rsp_valid,
   input  asa_rsp_type rsp_payload,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MASK13 = 13'h1FFF;

   int pen_col;
   int shelf_top;
   int shelf_h;
   int atlas_w;
   int atlas_h;
   int errors = 0;

   asa_rsp_type placement_q[$];
   asa_rsp_type want;

   task automatic flag_mismatch(string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(string name, int got, int exp_val);
      if (got != exp_val)
         flag_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
   endtask

   function automatic void clear_atlas();
      pen_col   = 0;
      shelf_top = 0;
      shelf_h   = 0;
      atlas_w   = DEF_START_WIDTH;
      atlas_h   = DEF_START_HEIGHT;
   endfunction

   function automatic asa_rsp_type place_cell(asa_req_type beat);
      asa_rsp_type r;
      int cw;
      int ch;
      int need;
      int nw;
      int nh;
      r        = '0;
      r.status = STATUS_OK;
      cw       = beat.cell_width;
      ch       = beat.cell_height;
      if (beat.cmd == CMD_RESTART) begin
         clear_atlas();
      end else if (cw == 0 || ch == 0) begin
         r.status = STATUS_ZERO;
      end else begin
         nw = atlas_w;
         while (nw < cw && nw < DEF_MAX_SIZE && nw != 0)
            nw = nw * 2;
         if (nw > DEF_MAX_SIZE || nw < cw) begin
            r.status = STATUS_SPACE;
         end else begin
            atlas_w = nw & MASK13;
            if (pen_col + cw > atlas_w) begin
               pen_col   = 0;
               shelf_top = (shelf_top + shelf_h) & MASK13;
               shelf_h   = 0;
            end
            need = shelf_top + ch;
            if (need > atlas_h) begin
               nh = atlas_h;
               while (nh < need && nh < DEF_MAX_SIZE) begin
                  if (nh < DEF_DOUBLING_LIMIT)
                     nh = (nh == 0) ? 1 : nh * 2;
                  else
                     nh = nh + DEF_HEIGHT_STEP;
               end
               if (nh > DEF_MAX_SIZE || nh < need)
                  r.status = STATUS_SPACE;
               else
                  atlas_h = nh & MASK13;
            end
            if (r.status == STATUS_OK) begin
               if (ch > shelf_h)
                  shelf_h = ch;
               r.origin_x = pen_col[DIM_W-1:0];
               r.origin_y = shelf_top[DIM_W-1:0];
               pen_col    = (pen_col + cw) & MASK13;
            end
         end
      end
      r.atlas_width  = atlas_w[SIZE_W-1:0];
      r.atlas_height = atlas_h[SIZE_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_atlas();
         placement_q.delete();
      end else begin
         if (rsp_valid) begin
            if (placement_q.size() == 0) begin
               flag_mismatch("result beat with no request pending");
            end else begin
               want = placement_q.pop_front();
               check_field("status", rsp_payload.status, want.status);
               check_field("origin_x", rsp_payload.origin_x, want.origin_x);
               check_field("origin_y", rsp_payload.origin_y, want.origin_y);
               check_field("atlas_width", rsp_payload.atlas_width, want.atlas_width);
               check_field("atlas_height", rsp_payload.atlas_height, want.atlas_height);
            end
         end
         if (start && !busy)
            placement_q = {placement_q, place_cell(req_payload)};
      end
      outstanding <= placement_q.size();
      fail_count  <= errors;
   end

endmodule

FILE: verif/testbench.sv
// Top of the atlas shelf allocator testbench: clock, reset, request stimulus,
// watchdog and verdict. Depends on asa_pkg, the allocator and its checker.
module testbench import asa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 800;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        rsp_valid;
   asa_req_type req_payload;
   asa_rsp_type rsp_payload;
   int          fail_count;
   int          outstanding;
   int          stall_cycles = 0;
   bit          burst_mode = 1'b0;

   atlas_shelf_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   atlas_placement_checker u_placement (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("atlas_shelf_allocator verification failed");
      $finish;
   end

   function automatic asa_req_type make_beat(logic cmd, logic [DIM_W-1:0] w,
                                             logic [DIM_W-1:0] h);
      asa_req_type beat;
      beat.cmd         = cmd;
      beat.cell_width  = w;
      beat.cell_height = h;
      return beat;
   endfunction

   function automatic asa_req_type random_beat();
      int roll;
      asa_req_type beat;
      roll = $urandom_range(0, 99);
      beat = make_beat(CMD_ALLOC, DIM_W'($urandom_range(1, 96)),
                       DIM_W'($urandom_range(1, 40)));
      if (roll < 4) begin
         beat = make_beat(CMD_RESTART, DIM_W'($urandom_range(0, 4095)),
                          DIM_W'($urandom_range(0, 4095)));
      end else if (roll < 9) begin
         case ($urandom_range(0, 2))
            0: beat.cell_width = '0;
            1: beat.cell_height = '0;
            default: beat = make_beat(CMD_ALLOC, '0, '0);
         endcase
      end else if (roll < 15) begin
         beat.cell_width  = DIM_W'($urandom_range(0, 4095));
         beat.cell_height = DIM_W'($urandom_range(0, 4095));
      end else if (roll < 25) begin
         beat.cell_width  = DIM_W'($urandom_range(97, 1500));
         beat.cell_height = DIM_W'($urandom_range(41, 400));
      end
      return beat;
   endfunction

   task automatic send_beat(asa_req_type beat);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_beat(make_beat(CMD_RESTART, 12'hFFF, 12'hFFF));
      send_beat(make_beat(CMD_ALLOC, 12'd0, 12'd5));
      send_beat(make_beat(CMD_ALLOC, 12'd5, 12'd0));
      send_beat(make_beat(CMD_ALLOC, 12'd0, 12'd0));
      send_beat(make_beat(CMD_ALLOC, 12'd1, 12'd1));
      send_beat(make_beat(CMD_ALLOC, 12'd4095, 12'd1));
      send_beat(make_beat(CMD_ALLOC, 12'd1, 12'd4095));
      send_beat(make_beat(CMD_ALLOC, 12'd2, 12'd2));
      send_beat(make_beat(CMD_RESTART, 12'd0, 12'd0));
      send_beat(make_beat(CMD_ALLOC, 12'd600, 12'd10));
      send_beat(make_beat(CMD_ALLOC, 12'd1100, 12'd10));
      send_beat(make_beat(CMD_ALLOC, 12'd2100, 12'd300));
      send_beat(make_beat(CMD_ALLOC, 12'd300, 12'd2000));
      send_beat(make_beat(CMD_ALLOC, 12'd10, 12'd1800));
      send_beat(make_beat(CMD_ALLOC, 12'd4095, 12'd1800));
      send_beat(make_beat(CMD_ALLOC, 12'd4095, 12'd1796));
      send_beat(make_beat(CMD_RESTART, 12'h555, 12'hAAA));
      send_beat(make_beat(CMD_ALLOC, 12'd4095, 12'd4095));
      send_beat(make_beat(CMD_ALLOC, 12'd4095, 12'd4095));
      send_beat(make_beat(CMD_ALLOC, 12'd2048, 12'd0));
      send_beat(make_beat(CMD_RESTART, 12'hAAA, 12'h555));
      wait_drained();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 40 == 0)
            burst_mode = ($urandom_range(0, 2) == 0);
         if (n % 200 == 100)
            wait_drained();
         send_beat(random_beat());
      end
      wait_drained();
      repeat (24) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("atlas_shelf_allocator verification clean");
      else
         $display("atlas_shelf_allocator verification failed");
      $finish;
   end

endmodule
